>>> rtl/core/slg_pkg.sv
// Package for the sample-limited gate: field widths, reset values, register
// indexes and opcodes shared by the interfaces and the top level.
// Depends on nothing.
`default_nettype none

package slg_pkg;

  localparam int TAG_W      = 16;
  localparam int LIMIT_W    = 32;
  localparam int CAP_W      = 5;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;
  localparam int REG_IDX_W  = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd900000;
  localparam logic [CAP_W-1:0]   CAP_RESET   = 5'd16;

  // Register indexes (byte address is four times the index).
  localparam logic [REG_IDX_W-1:0] REG_BUFFER_ENABLE   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DATA_LIMIT      = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BUFFER_CAPACITY = 2'd2;

  // Input item opcodes.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_CMD  = 1'b1;

endpackage : slg_pkg

`default_nettype wire

>>> rtl/core/slg_in_if.sv
// Input channel of the sample-limited gate: valid/ready plus one item.
// Depends on slg_pkg for the tag width.
`default_nettype none

interface slg_in_if #(
  parameter int LENGTH_BITS = 16
);
  import slg_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   op;
  logic [LENGTH_BITS-1:0] set_length;
  logic [TAG_W-1:0]       set_tag;
  logic                   open_value;

  modport source (output valid, output op, output set_length, output set_tag,
                  output open_value, input ready);
  modport sink   (input valid, input op, input set_length, input set_tag,
                  input open_value, output ready);
endinterface : slg_in_if

`default_nettype wire

>>> rtl/core/slg_out_if.sv
// Result channel of the sample-limited gate: valid/ready plus one item.
// Depends on slg_pkg for the tag width.
`default_nettype none

interface slg_out_if #(
  parameter int LENGTH_BITS = 16
);
  import slg_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [TAG_W-1:0]       out_tag;
  logic [LENGTH_BITS-1:0] out_length;
  logic                   last;

  modport source (output valid, output out_tag, output out_length, output last,
                  input ready);
  modport sink   (input valid, input out_tag, input out_length, input last,
                  output ready);
endinterface : slg_out_if

`default_nettype wire

>>> rtl/core/slg_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module slg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule : slg_ram

`default_nettype wire

>>> rtl/core/sample_limited_gate_with_set_buffer.sv
// Sample-limited gate with a set buffer, top level.
// Depends on slg_pkg, slg_in_if, slg_out_if and slg_ram.
//
// Usage. Items arrive on in_ch: either a data set (tag and sample count) or
// a command that sets the gate's open flag. An open gate passes sets to
// out_ch and adds their counts to a running total; once the total passes
// data_limit the gate closes and the total clears. While closed, sets are
// kept in a circular buffer (when buffer_enable is set) and are flushed,
// oldest first, ahead of the next set that passes an open gate. Each data
// set that passes gives one or more results, the last marked. The user must
// write registers on the APB-style port only when idle (not enforced).
//
// Timing. in_ch.ready is high only while the block waits for an item. A
// command, a buffered or dropped set is settled in ST_EVAL. A passing set
// ends in ST_LAST; if the buffer holds sets it first visits ST_FLUSH for
// each flushed set, ST_FLUSH_RD between them, and a buffered set that
// closes the gate ends the flush. The buffer memory has a registered read
// and each flushed entry needs a fresh read at the new head. Results leave
// through a single output register, so a stalled receiver holds the flush;
// a new item is still taken while the final result waits in that register.
//
// Reset (synchronous, active low) closes the gate, clears the total,
// empties the buffer and restores the register defaults. The buffer memory
// itself is not cleared; the fill count says which entries hold sets.
`default_nettype none

module sample_limited_gate_with_set_buffer #(
  parameter int BUFFER_DEPTH = 16,
  parameter int LENGTH_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  slg_in_if.sink                            in_ch,
  slg_out_if.source                         out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [slg_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [slg_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [slg_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import slg_pkg::*;

  // Widths derived from the buffer depth: head index, fill count and a
  // working width for head/fill sums that may reach twice the depth.
  localparam int HW    = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int FW    = $clog2(BUFFER_DEPTH + 1);
  localparam int SW    = FW + 1;
  localparam int CMP_W = (SW > CAP_W) ? SW : CAP_W;
  localparam int TOT_W = LIMIT_W + 1;
  localparam int ENT_W = TAG_W + LENGTH_BITS;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_EVAL     = 5'b00010,
    ST_FLUSH_RD = 5'b00100,
    ST_FLUSH    = 5'b01000,
    ST_LAST     = 5'b10000
  } state_t;

  // Configuration registers.
  logic               buf_en_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [CAP_W-1:0]   cap_r;

  // Control state.
  state_t             state_r, state_nxt;
  logic               gate_r, gate_nxt;
  logic [TOT_W-1:0]   total_r, total_nxt;
  logic [HW-1:0]      head_r, head_nxt;
  logic [FW-1:0]      fill_r, fill_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Held input item.
  logic                   op_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic [TAG_W-1:0]       tag_r;
  logic                   open_r;

  // Output register payload.
  logic [TAG_W-1:0]       out_tag_r;
  logic [LENGTH_BITS-1:0] out_len_r;
  logic                   out_last_r;

  logic                   in_accept;
  logic                   out_free;
  logic                   load_out;
  logic [TAG_W-1:0]       load_tag;
  logic [LENGTH_BITS-1:0] load_len;
  logic                   load_last;
  logic                   do_push;
  logic                   do_pop;

  // Buffer memory signals.
  logic                   mem_we;
  logic [HW-1:0]          mem_waddr;
  logic [ENT_W-1:0]       mem_rdata;
  logic [TAG_W-1:0]       rd_tag;
  logic [LENGTH_BITS-1:0] rd_len;

  // Push arithmetic.
  logic [SW-1:0]    cap_eff;
  logic [SW-1:0]    fill_ext;
  logic [HW-1:0]    push_head;
  logic [SW-1:0]    push_fill;
  logic [TOT_W-1:0] sum_in;
  logic [TOT_W-1:0] sum_fl;
  logic [TOT_W-1:0] limit_ext;

  function automatic logic [HW-1:0] wrap_idx(input logic [SW-1:0] v);
    if (v >= SW'(BUFFER_DEPTH)) begin
      wrap_idx = HW'(v - SW'(BUFFER_DEPTH));
    end else begin
      wrap_idx = HW'(v);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; reads are
  // served from a plain mux and never wait.
  // ---------------------------------------------------------------------
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[REG_IDX_W+1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_en_r <= 1'b0;
      limit_r  <= LIMIT_RESET;
      cap_r    <= CAP_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_BUFFER_ENABLE:   buf_en_r <= pwdata[0];
        REG_DATA_LIMIT:      limit_r  <= pwdata[LIMIT_W-1:0];
        REG_BUFFER_CAPACITY: cap_r    <= pwdata[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_BUFFER_ENABLE:   prdata = APB_DATA_W'(buf_en_r);
      REG_DATA_LIMIT:      prdata = APB_DATA_W'(limit_r);
      REG_BUFFER_CAPACITY: prdata = APB_DATA_W'(cap_r);
      default:             prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Set buffer. The read address always follows the head, so the entry at
  // the head is on the read port in the cycle after the head settles.
  // ---------------------------------------------------------------------
  slg_ram #(
    .WIDTH (ENT_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata ({tag_r, len_r}),
    .raddr (head_r),
    .rdata (mem_rdata)
  );

  assign rd_tag = mem_rdata[ENT_W-1 -: TAG_W];
  assign rd_len = mem_rdata[LENGTH_BITS-1:0];

  // Effective capacity saturates at the physical depth. A push into a
  // buffer at or above capacity first drops enough of the oldest sets to
  // leave exactly one free place.
  always_comb begin
    if (CMP_W'(cap_r) > CMP_W'(BUFFER_DEPTH)) begin
      cap_eff = SW'(BUFFER_DEPTH);
    end else begin
      cap_eff = SW'(cap_r);
    end
    fill_ext = SW'(fill_r);
    if (fill_ext >= cap_eff) begin
      push_head = wrap_idx(SW'(head_r) + (fill_ext - cap_eff + SW'(1)));
      push_fill = cap_eff - SW'(1);
    end else begin
      push_head = head_r;
      push_fill = fill_ext;
    end
    mem_waddr = wrap_idx(SW'(push_head) + push_fill);
    mem_we    = do_push && (cap_eff != '0);
  end

  // Running-total sums for the arriving set and for the set at the head.
  assign limit_ext = TOT_W'(limit_r);
  assign sum_in    = total_r + TOT_W'(len_r);
  assign sum_fl    = total_r + TOT_W'(rd_len);

  // ---------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    gate_nxt  = gate_r;
    total_nxt = total_r;
    do_push   = 1'b0;
    do_pop    = 1'b0;
    load_out  = 1'b0;
    load_tag  = tag_r;
    load_len  = len_r;
    load_last = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (op_r == OP_CMD) begin
          gate_nxt  = open_r;
          state_nxt = ST_IDLE;
        end else if (!gate_r) begin
          do_push   = buf_en_r;
          state_nxt = ST_IDLE;
        end else if (sum_in > limit_ext) begin
          // The set closes the gate; it is buffered if enabled, never sent.
          gate_nxt  = 1'b0;
          total_nxt = '0;
          do_push   = buf_en_r;
          state_nxt = ST_IDLE;
        end else begin
          total_nxt = sum_in;
          // The head entry has been on the read port since the accept.
          state_nxt = (fill_r != '0) ? ST_FLUSH : ST_LAST;
        end
      end
      ST_FLUSH_RD: begin
        state_nxt = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (sum_fl > limit_ext) begin
          // The head set closes the gate and stays in the buffer; the
          // arriving set still goes out.
          gate_nxt  = 1'b0;
          total_nxt = '0;
          state_nxt = ST_LAST;
        end else if (out_free) begin
          load_out  = 1'b1;
          load_tag  = rd_tag;
          load_len  = rd_len;
          load_last = 1'b0;
          total_nxt = sum_fl;
          do_pop    = 1'b1;
          state_nxt = (fill_r > FW'(1)) ? ST_FLUSH_RD : ST_LAST;
        end
      end
      ST_LAST: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (mem_we) begin
      head_nxt = push_head;
      fill_nxt = FW'(push_fill + SW'(1));
    end else if (do_pop) begin
      head_nxt = wrap_idx(SW'(head_r) + SW'(1));
      fill_nxt = fill_r - FW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      gate_r      <= 1'b0;
      total_r     <= '0;
      head_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gate_r      <= gate_nxt;
      total_r     <= total_nxt;
      head_r      <= head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r   <= in_ch.op;
      len_r  <= in_ch.set_length;
      tag_r  <= in_ch.set_tag;
      open_r <= in_ch.open_value;
    end
    if (load_out) begin
      out_tag_r  <= load_tag;
      out_len_r  <= load_len;
      out_last_r <= load_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_tag    = out_tag_r;
  assign out_ch.out_length = out_len_r;
  assign out_ch.last       = out_last_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(BUFFER_DEPTH))
    else $error("buffer fill count exceeds the depth");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_ch.ready))
    else $error("output register loaded while it still holds a result");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |-> (fill_r != '0))
    else $error("flush popped an empty buffer");

  a_flush_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && load_out) |=> (out_valid_r && !out_last_r))
    else $error("flushed set marked as the final result");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LAST && load_out) |=> (state_r == ST_IDLE && out_last_r))
    else $error("final result did not end the item");

endmodule : sample_limited_gate_with_set_buffer

`default_nettype wire
